// ===== sv/bitmap_contiguous_block_allocator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap block allocator
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef BITMAP_CONTIGUOUS_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_CONTIGUOUS_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check that is suspended while reset is high.
`define BCBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that also holds during reset.
`define BCBA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BCBA_ASSERT(label, prop, msg)
`define BCBA_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== sv/bcba_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Field widths, default geometry, command and status codes, sequencer states and payload types.
// ----------------------------------------------------------------------------
package bcba_pkg;

  // Fixed field widths of the request and response.
  localparam int ADDR_W   = 22;
  localparam int COUNT_W  = 11;
  localparam int INDEX_W  = 10;

  // Default geometry of the managed region.
  localparam int DEF_TOTAL_BLOCKS    = 1024;
  localparam int DEF_BYTES_PER_BLOCK = 4096;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SPACE  = 2'd1,
    STAT_BAD_COUNT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_DIV,
    ST_FREE,
    ST_QUERY,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_t               command;
    logic [COUNT_W-1:0] block_count;
    logic [ADDR_W-1:0]  address;
    logic [INDEX_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] start_address;
    logic              block_free;
  } rsp_t;

endpackage

// ===== sv/bitmap_contiguous_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Bitmap first-fit block allocator
// Sequencer that walks a one-bit-per-block used map held in a RAM.
// ----------------------------------------------------------------------------
//   Requests arrive on req_valid / req_stall with a req_t payload; responses
//   leave on rsp_valid / rsp_stall with an rsp_t payload, one per request.
//   A transaction is taken when valid is high and stall is low. The block
//   works on one request at a time and stalls the request side until it is
//   done; the response register lets the next request start while an earlier
//   response still waits to be taken. The map RAM takes one read and one
//   write per cycle. What each request does:
//     allocate: a first-fit scan of the map, then a run found is marked used.
//     free:     a reciprocal multiply finds the block index, then blocks are
//               cleared until the count runs out or the map ends.
//     query: one map read when the index is in the map.  clear: a pass over
//     the whole map.  bad count: the response is given straight away.
//   After reset the map is cleared by a pass over every block, during which
//   no request is taken. A stalled response holds in the output register; a
//   finished request waits in its last state until that register is free.
// ----------------------------------------------------------------------------
`include "bitmap_contiguous_block_allocator_core_assert.svh"

module bitmap_contiguous_block_allocator_core #(
  parameter int TOTAL_BLOCKS    = bcba_pkg::DEF_TOTAL_BLOCKS,
  parameter int BYTES_PER_BLOCK = bcba_pkg::DEF_BYTES_PER_BLOCK
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  bcba_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output bcba_pkg::rsp_t rsp
);
  import bcba_pkg::*;

  localparam int IDX_W = $clog2(TOTAL_BLOCKS);
  localparam int CNT_W = $clog2(TOTAL_BLOCKS + 1);
  localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  // Sequencer registers.
  state_t             state, state_next;
  logic               clr_reply, clr_reply_next;
  rsp_t               res, res_next;
  logic [CNT_W-1:0]   rd_idx, rd_idx_next;
  logic               rd_pend, rd_pend_next;
  logic [IDX_W-1:0]   chk_idx, chk_idx_next;
  logic [CNT_W-1:0]   run, run_next;
  logic [IDX_W-1:0]   run_first, run_first_next;
  logic [ADDR_W-1:0]  run_addr, run_addr_next;
  logic [ADDR_W-1:0]  cur_addr, cur_addr_next;
  logic [COUNT_W-1:0] cnt, cnt_next;
  logic [ADDR_W-1:0]  blk, blk_next;
  logic               rsp_valid_next;
  rsp_t               rsp_next;

  // Map RAM and divider connections.
  logic               wr_en, wr_data, rd_en, rd_data;
  logic [IDX_W-1:0]   wr_addr, rd_addr;
  logic               div_start, div_done;
  logic [ADDR_W-1:0]  div_quo;

  bcba_ram #(
    .WIDTH (1),
    .DEPTH (TOTAL_BLOCKS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bcba_div #(
    .BYTES_PER_BLOCK (BYTES_PER_BLOCK)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req.address),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign req_stall = (state != ST_IDLE);

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_reply <= 1'b0;
      rsp_valid <= 1'b0;
      rd_pend   <= 1'b0;
      blk       <= '0;
    end else begin
      state     <= state_next;
      clr_reply <= clr_reply_next;
      rsp_valid <= rsp_valid_next;
      rd_pend   <= rd_pend_next;
      blk       <= blk_next;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    res       <= res_next;
    rsp       <= rsp_next;
    rd_idx    <= rd_idx_next;
    chk_idx   <= chk_idx_next;
    run       <= run_next;
    run_first <= run_first_next;
    run_addr  <= run_addr_next;
    cur_addr  <= cur_addr_next;
    cnt       <= cnt_next;
  end

  // Next state and RAM control.
  always_comb begin
    logic             found;
    logic [CNT_W-1:0] run_inc;
    found          = 1'b0;
    run_inc        = run + CNT_W'(1);
    state_next     = state;
    clr_reply_next = clr_reply;
    res_next       = res;
    rd_idx_next    = rd_idx;
    rd_pend_next   = 1'b0;
    chk_idx_next   = chk_idx;
    run_next       = run;
    run_first_next = run_first;
    run_addr_next  = run_addr;
    cur_addr_next  = cur_addr;
    cnt_next       = cnt;
    blk_next       = blk;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    wr_en          = 1'b0;
    wr_addr        = blk[IDX_W-1:0];
    wr_data        = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = rd_idx[IDX_W-1:0];
    div_start      = 1'b0;

    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          res_next = '{status: STAT_OK, start_address: '0, block_free: 1'b0};
          cnt_next = req.block_count;
          case (req.command)
            CMD_ALLOC: begin
              if ((req.block_count == '0) ||
                  (CMP_W'(req.block_count) > CMP_W'(TOTAL_BLOCKS))) begin
                res_next.status = STAT_BAD_COUNT;
                state_next      = ST_DONE;
              end else begin
                rd_idx_next   = '0;
                chk_idx_next  = '0;
                run_next      = '0;
                cur_addr_next = '0;
                state_next    = ST_SCAN;
              end
            end
            CMD_FREE: begin
              div_start  = 1'b1;
              state_next = ST_DIV;
            end
            CMD_QUERY: begin
              if (CMP_W'(req.block_index) < CMP_W'(TOTAL_BLOCKS)) begin
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(req.block_index);
                state_next = ST_QUERY;
              end else begin
                state_next = ST_DONE;
              end
            end
            CMD_CLEAR: begin
              blk_next       = '0;
              clr_reply_next = 1'b1;
              state_next     = ST_CLEAR;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end

      // Streamed first-fit walk: read one block ahead, check the one returned.
      ST_SCAN: begin
        if (rd_idx < CNT_W'(TOTAL_BLOCKS)) begin
          rd_en        = 1'b1;
          rd_pend_next = 1'b1;
          rd_idx_next  = rd_idx + CNT_W'(1);
        end
        if (rd_pend) begin
          chk_idx_next  = chk_idx + IDX_W'(1);
          cur_addr_next = cur_addr + ADDR_W'(BYTES_PER_BLOCK);
          if (rd_data) begin
            run_next = '0;
          end else begin
            run_next = run_inc;
            if (run == '0) begin
              run_first_next = chk_idx;
              run_addr_next  = cur_addr;
            end
            found = (CMP_W'(run_inc) == CMP_W'(cnt));
          end
        end else if (rd_idx == CNT_W'(TOTAL_BLOCKS)) begin
          res_next.status = STAT_NO_SPACE;
          state_next      = ST_DONE;
        end
        if (found) begin
          res_next.start_address = run_addr_next;
          blk_next               = ADDR_W'(run_first_next);
          rd_pend_next           = 1'b0;
          state_next             = ST_MARK;
        end
      end

      // Mark the found run used, one block per cycle.
      ST_MARK: begin
        wr_en    = 1'b1;
        wr_data  = 1'b1;
        blk_next = blk + ADDR_W'(1);
        cnt_next = cnt - COUNT_W'(1);
        if (cnt == COUNT_W'(1)) begin
          state_next = ST_DONE;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          blk_next   = div_quo;
          state_next = ST_FREE;
        end
      end

      // Free blocks in range until the count runs out or the map ends.
      ST_FREE: begin
        if ((cnt == '0) || (blk >= ADDR_W'(TOTAL_BLOCKS))) begin
          state_next = ST_DONE;
        end else begin
          wr_en    = 1'b1;
          blk_next = blk + ADDR_W'(1);
          cnt_next = cnt - COUNT_W'(1);
        end
      end

      ST_QUERY: begin
        res_next.block_free = !rd_data;
        state_next          = ST_DONE;
      end

      // Clearing pass, after reset or on a clear command.
      ST_CLEAR: begin
        wr_en    = 1'b1;
        blk_next = blk + ADDR_W'(1);
        if (blk == ADDR_W'(TOTAL_BLOCKS - 1)) begin
          state_next = clr_reply ? ST_DONE : ST_IDLE;
        end
      end

      // Hand the result over once the output register is free.
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next = 1'b1;
          rsp_next       = res;
          clr_reply_next = 1'b0;
          state_next     = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Checks on the sequencer.
  `BCBA_ASSERT(a_idle_no_write, (state == ST_IDLE) |-> !wr_en, "map written while idle")
  `BCBA_ASSERT(a_rsp_from_done, $rose(rsp_valid) |-> ($past(state) == ST_DONE), "response without finish")
  `BCBA_ASSERT(a_fail_zero, (rsp_valid && (rsp.status != STAT_OK)) |-> ((rsp.start_address == '0) && !rsp.block_free), "failed request with payload")
  `BCBA_ASSERT_ALWAYS(a_reset_clears, $past(rst) |-> (state == ST_CLEAR), "no clearing pass after reset")

endmodule

// ===== sv/bcba_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bcba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/bcba_div.sv =====
// ----------------------------------------------------------------------------
// Reciprocal address divider
// Turns a byte address into a block index by one multiply with the rounded-up
// reciprocal of the block size; the quotient is registered on start.
// ----------------------------------------------------------------------------
module bcba_div #(
  parameter int BYTES_PER_BLOCK = bcba_pkg::DEF_BYTES_PER_BLOCK
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [bcba_pkg::ADDR_W-1:0] dividend,
  output logic                    done,
  output logic [bcba_pkg::ADDR_W-1:0] quotient
);
  import bcba_pkg::*;

  // With SHIFT = ADDR_W + ceil(log2(block size)) and the reciprocal rounded
  // up, the top bits of the product are the exact floor quotient for every
  // ADDR_W-bit address.
  localparam int SHIFT = ADDR_W + $clog2(BYTES_PER_BLOCK);
  localparam int M_W   = ADDR_W + 2;
  localparam int P_W   = ADDR_W + M_W;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SHIFT) + 64'(BYTES_PER_BLOCK) - 64'd1) / 64'(BYTES_PER_BLOCK);
  localparam logic [M_W-1:0] RECIP = M_W'(RECIP_WIDE);

  logic [P_W-1:0] prod;

  // Multiply by the reciprocal of the block size.
  assign prod = P_W'(dividend) * P_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // Quotient register, loaded when a divide is started.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= ADDR_W'(prod >> SHIFT);
    end
  end

endmodule

// ===== sim/tb_bitmap_contiguous_block_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the bitmap first-fit block allocator
// Sends allocate, free, query and clear requests with random idle gaps on
// both channels. A scoreboard keeps its own copy of the used map, predicts
// each response when its request is taken, and compares every response
// field by field in order.
// ----------------------------------------------------------------------------
module tb_bitmap_contiguous_block_allocator_core;
  import bcba_pkg::*;

  localparam int NBLK         = DEF_TOTAL_BLOCKS;
  localparam int BPB          = DEF_BYTES_PER_BLOCK;
  localparam int RANDOM_ITEMS = 560;
  localparam int LONG_HOLD    = 400;
  localparam int TAIL_CYCLES  = 50;
  localparam int MAX_REPORTS  = 10;
  // Allow for the slowest request (a scan to the last block followed by
  // marking the whole map), the long response hold-off, the longest gaps
  // and the map clearing pass after reset, several times over.
  localparam int IDLE_LIMIT   = 20000;

  typedef struct {
    int first;
    int count;
  } alloc_run_t;

  // Scoreboard: mirrors the used map and holds the responses still to come.
  class alloc_map_scoreboard;
    bit         used_map [NBLK];
    rsp_t       expected_rsp_q [$];
    alloc_run_t live_runs [$];
    int         fail_count;
    int         checked_count;
    int         placed_count;
    int         no_room_count;
    int         rejected_count;
    int         free_count;
    int         query_count;
    int         clear_count;

    // Applies one accepted request to the map and queues its response.
    function void predict_request(req_t r);
      rsp_t       want;
      int         run_len;
      int         first;
      bit         found;
      longint     base;
      alloc_run_t placed;
      want = '0;
      want.status = STAT_OK;
      case (r.command)
        CMD_ALLOC: begin
          if (r.block_count == 0 || r.block_count > NBLK) begin
            want.status = STAT_BAD_COUNT;
            rejected_count++;
          end else begin
            run_len = 0;
            found = 1'b0;
            first = 0;
            // First fit: the lowest start of a long enough free run.
            for (int i = 0; i < NBLK && !found; i++) begin
              if (used_map[i]) begin
                run_len = 0;
              end else begin
                run_len++;
                if (run_len == r.block_count) begin
                  first = i + 1 - run_len;
                  found = 1'b1;
                end
              end
            end
            if (found) begin
              for (int i = first; i < first + r.block_count; i++) used_map[i] = 1'b1;
              want.start_address = ADDR_W'(longint'(first) * BPB);
              placed.first = first;
              placed.count = r.block_count;
              live_runs.push_back(placed);
              placed_count++;
            end else begin
              want.status = STAT_NO_SPACE;
              no_room_count++;
            end
          end
        end
        CMD_FREE: begin
          // Blocks past the end of the map are ignored.
          base = r.address / BPB;
          for (int k = 0; k < r.block_count; k++) begin
            if (base + k < NBLK) used_map[base + k] = 1'b0;
          end
          free_count++;
        end
        CMD_QUERY: begin
          if (r.block_index < NBLK) want.block_free = !used_map[r.block_index];
          query_count++;
        end
        CMD_CLEAR: begin
          foreach (used_map[i]) used_map[i] = 1'b0;
          live_runs.delete();
          clear_count++;
        end
      endcase
      expected_rsp_q.push_back(want);
    endfunction

    // Compares one accepted response with the oldest prediction.
    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_rsp_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("ERROR: %0t unexpected response status=%0d start=0x%06h free=%0b",
                   $time, got.status, got.start_address, got.block_free);
        return;
      end
      want = expected_rsp_q.pop_front();
      checked_count++;
      if (got.status !== want.status || got.start_address !== want.start_address ||
          got.block_free !== want.block_free) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("ERROR: %0t response %0d: expected status=%0d start=0x%06h free=%0b,",
                   $time, checked_count, want.status, want.start_address, want.block_free);
          $display("       got status=%0d start=0x%06h free=%0b",
                   got.status, got.start_address, got.block_free);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  alloc_map_scoreboard sb;
  bit quiet_phase;
  bit long_hold_req;
  int idle_cycles;

  bitmap_contiguous_block_allocator_core #(
    .TOTAL_BLOCKS    (NBLK),
    .BYTES_PER_BLOCK (BPB)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic req_t make_req(cmd_t c, int cnt, int addr, int idx);
    req_t r;
    r.command     = c;
    r.block_count = COUNT_W'(cnt);
    r.address     = ADDR_W'(addr);
    r.block_index = INDEX_W'(idx);
    return r;
  endfunction

  // Random request: mostly allocations and frees of runs that were placed,
  // with queries around them, some stray frees, bad counts and clears.
  function automatic req_t random_request();
    req_t       r;
    int         pick;
    int         sel;
    alloc_run_t run;
    r.command     = CMD_QUERY;
    r.block_count = COUNT_W'($urandom);
    r.address     = ADDR_W'($urandom);
    r.block_index = INDEX_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r.command = CMD_ALLOC;
      sel = $urandom_range(0, 99);
      if (sel < 72) r.block_count = COUNT_W'($urandom_range(1, 16));
      else if (sel < 91) r.block_count = COUNT_W'($urandom_range(17, 128));
      else if (sel < 96) r.block_count = COUNT_W'($urandom_range(129, NBLK));
      else if (sel < 98) r.block_count = '0;
      else r.block_count = COUNT_W'($urandom_range(NBLK + 1, 2047));
    end else if (pick < 65 && sb.live_runs.size() != 0) begin
      // Give back a placed run, from a random, usually unaligned address inside its first block.
      sel = $urandom_range(0, sb.live_runs.size() - 1);
      run = sb.live_runs[sel];
      sb.live_runs.delete(sel);
      r.command = CMD_FREE;
      r.address = ADDR_W'(run.first * BPB + $urandom_range(0, BPB - 1));
      if ($urandom_range(0, 4) == 0) r.block_count = COUNT_W'($urandom_range(1, run.count + 8));
      else r.block_count = COUNT_W'(run.count);
    end else if (pick < 70) begin
      r.command = CMD_FREE;
      if ($urandom_range(0, 4) != 0) r.block_count = COUNT_W'($urandom_range(0, 32));
    end else if (pick < 98) begin
      if (sb.live_runs.size() != 0 && $urandom_range(0, 1) == 0) begin
        // Look at the edges and inside of a placed run.
        run = sb.live_runs[$urandom_range(0, sb.live_runs.size() - 1)];
        r.block_index = INDEX_W'(run.first - 1 + $urandom_range(0, run.count + 1));
      end
    end else begin
      r.command = CMD_CLEAR;
    end
    return r;
  endfunction

  // Offers one request after a random gap (none in the quiet phase) and returns at the falling edge
  // after it was taken, with valid still high.
  task automatic send_item(input req_t item);
    int gap;
    gap = quiet_phase ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       = item;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    do @(negedge clk); while (sb.expected_rsp_q.size() != 0);
  endtask

  // Observe both channels at the rising edge, and watch for a hang.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
      if (req_valid && !req_stall) sb.predict_request(req);
      if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Response side: random stalls, a quiet stretch, and one long hold-off.
  initial begin
    int stall_len;
    rsp_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        rsp_stall = 1'b0;
        @(negedge clk);
      end else if (quiet_phase) begin
        rsp_stall = 1'b0;
        @(negedge clk);
      end else begin
        stall_len = pick_gap();
        if (stall_len > 0) begin
          rsp_stall = 1'b1;
          repeat (stall_len) @(negedge clk);
        end
        rsp_stall = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
    end
  end

  // Request side: reset, directed corners, then random traffic.
  initial begin
    req_t directed_items [$];
    int   n;
    rst           = 1'b1;
    req_valid     = 1'b0;
    req           = '0;
    quiet_phase   = 1'b0;
    long_hold_req = 1'b0;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Bad counts, a full map, unaligned and overlong frees, a zero-count
    // free, a double free, and clears.
    directed_items.push_back(make_req(CMD_QUERY, 0, 0, 0));
    directed_items.push_back(make_req(CMD_ALLOC, 0, 0, 0));
    directed_items.push_back(make_req(CMD_ALLOC, NBLK + 1, 0, 0));
    directed_items.push_back(make_req(CMD_ALLOC, 2047, 0, 0));
    directed_items.push_back(make_req(CMD_ALLOC, 1, 0, 0));
    directed_items.push_back(make_req(CMD_ALLOC, NBLK, 0, 0));
    directed_items.push_back(make_req(CMD_QUERY, 0, 0, 0));
    directed_items.push_back(make_req(CMD_ALLOC, NBLK - 1, 0, 0));
    directed_items.push_back(make_req(CMD_ALLOC, 1, 0, 0));
    directed_items.push_back(make_req(CMD_QUERY, 0, 0, NBLK - 1));
    directed_items.push_back(make_req(CMD_FREE, 3, 5 * BPB + 123, 0));
    directed_items.push_back(make_req(CMD_QUERY, 0, 0, 6));
    directed_items.push_back(make_req(CMD_ALLOC, 2, 0, 0));
    directed_items.push_back(make_req(CMD_ALLOC, 2, 0, 0));
    directed_items.push_back(make_req(CMD_FREE, 2047, 22'h3FFFFF, 0));
    directed_items.push_back(make_req(CMD_QUERY, 0, 0, NBLK - 1));
    directed_items.push_back(make_req(CMD_FREE, 0, 0, 0));
    directed_items.push_back(make_req(CMD_QUERY, 0, 0, 0));
    directed_items.push_back(make_req(CMD_FREE, 1, 0, 0));
    directed_items.push_back(make_req(CMD_FREE, 1, 0, 0));
    directed_items.push_back(make_req(CMD_ALLOC, 1, 0, 0));
    directed_items.push_back(make_req(CMD_CLEAR, 0, 0, 0));
    directed_items.push_back(make_req(CMD_ALLOC, NBLK, 0, 0));
    directed_items.push_back(make_req(CMD_QUERY, 0, 0, 512));
    directed_items.push_back(make_req(CMD_CLEAR, 0, 0, 0));
    foreach (directed_items[i]) send_item(directed_items[i]);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_phase = (n >= 200 && n < 260);
      // Hold the response side off so the block backs up into the request side.
      if (n == 100) long_hold_req = 1'b1;
      // Pause until every outstanding response has come back.
      if (n == 320) begin
        req_valid = 1'b0;
        wait_for_drain();
      end
      send_item(random_request());
    end
    req_valid = 1'b0;

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Summary: %0d allocations (%0d placed, %0d without room, %0d bad count),",
             sb.placed_count + sb.no_room_count + sb.rejected_count, sb.placed_count,
             sb.no_room_count, sb.rejected_count);
    $display("Summary: %0d frees, %0d queries, %0d clears; %0d responses compared.",
             sb.free_count, sb.query_count, sb.clear_count, sb.checked_count);
    if (sb.fail_count == 0 && sb.expected_rsp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
